FILE: rtl/core/lfpd_pkg.sv
`timescale 1ns / 1ps

package lfpd_pkg;

  // Width of the saturating error integral.
  localparam int unsigned INTEGRAL_BITS = 16;

  // Error is a signed value from -4 to +4. Its change per tick lies in -8..+8.
  localparam int unsigned ERR_W  = 4;
  localparam int unsigned DIFF_W = ERR_W + 1;

  // A gain times the integral is INTEGRAL_BITS + 9 bits wide. Two more bits
  // leave room for the sum of the three terms.
  localparam int unsigned PID_W  = INTEGRAL_BITS + 11;

  localparam int unsigned GAIN_W = 8;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_AW = 4;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_I     = 2'd1,
    REG_GAIN_D     = 2'd2,
    REG_BASE_SPEED = 2'd3
  } lfpd_reg_e;

  typedef struct packed {
    logic             hit;
    logic [ERR_W-1:0] err;
  } lfpd_decode_t;

  // Maps a sensor pattern to a line error. The leftmost sensor is bit 0.
  // Patterns that are not in the table give no hit.
  function automatic lfpd_decode_t decode_pattern(input logic [4:0] bits);
    lfpd_decode_t res;
    res.hit = 1'b1;
    res.err = '0;
    case (bits)
      5'b10000: res.err = 4'sd4;
      5'b11000: res.err = 4'sd3;
      5'b01000: res.err = 4'sd2;
      5'b01100: res.err = 4'sd1;
      5'b00100: res.err = 4'sd0;
      5'b00110: res.err = -4'sd1;
      5'b00010: res.err = -4'sd2;
      5'b00011: res.err = -4'sd3;
      5'b00001: res.err = -4'sd4;
      default:  res.hit = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/line_follower_pid_drive_core.sv
`timescale 1ns / 1ps

// Line-follower PID drive. Each sensor request on the slave stream is one
// control tick. The five sensor bits are decoded to a line error from -4 to +4.
// An all-zero pattern or one that is not listed keeps the previous error.
// The error is added to a saturating integral, and its change since the last
// tick is formed. The three terms are weighted by gain_p, gain_i and gain_d,
// summed, and clamped to plus or minus base_speed. A negative correction slows
// the left wheel by its magnitude, and a positive one slows the right wheel.
// The block takes one request every clock cycle unless the master side holds
// it back. The decode and integral update finish in the cycle of acceptance and
// are registered in the term stage; the three multiplies, the sum and the clamp
// follow it and are registered in the result register. Back-pressure from the
// master side stalls the pipeline in place and loses no requests. Write the gain
// and speed registers through the APB port only while no request is in flight.
module line_follower_pid_drive_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Configuration port. Registers lie at byte addresses 0, 4, 8 and 12.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfpd_pkg::CFG_AW-1:0]         paddr,
  input  logic [lfpd_pkg::CFG_DW-1:0]         pwdata,
  output logic [lfpd_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready,

  // Sensor requests. tdata: [4:0] sensor_bits, [7:5] zero.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lfpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

  // Drive results. tdata: [7:0] left_drive, [15:8] right_drive,
  // [19:16] line_error, [23:20] zero.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lfpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned IB = lfpd_pkg::INTEGRAL_BITS;

  // Configuration registers.
  logic [lfpd_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, base_speed_q;
  logic                        cfg_wr;
  lfpd_pkg::lfpd_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lfpd_pkg::lfpd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      base_speed_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lfpd_pkg::REG_GAIN_P:     gain_p_q     <= pwdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_GAIN_I:     gain_i_q     <= pwdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_GAIN_D:     gain_d_q     <= pwdata[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_BASE_SPEED: base_speed_q <= pwdata[lfpd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      lfpd_pkg::REG_GAIN_P:     prdata[lfpd_pkg::GAIN_W-1:0] = gain_p_q;
      lfpd_pkg::REG_GAIN_I:     prdata[lfpd_pkg::GAIN_W-1:0] = gain_i_q;
      lfpd_pkg::REG_GAIN_D:     prdata[lfpd_pkg::GAIN_W-1:0] = gain_d_q;
      lfpd_pkg::REG_BASE_SPEED: prdata[lfpd_pkg::GAIN_W-1:0] = base_speed_q;
      default:                  prdata = '0;
    endcase
  end

  // Pipeline flow control. The output register loads when it is empty or
  // being drained. The term stage moves whenever the output register can load.
  logic s1_vld_q, out_vld_q;
  logic out_load, s1_adv, in_acc;

  assign out_load      = !out_vld_q || m_axis_tready;
  assign s1_adv        = s1_vld_q && out_load;
  assign s_axis_tready = !s1_vld_q || out_load;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Controller state, updated at acceptance so that the next tick sees it.
  logic signed [lfpd_pkg::ERR_W-1:0] cur_err_q, cur_err_d;
  logic signed [lfpd_pkg::ERR_W-1:0] prev_err_q;
  logic signed [IB-1:0]              integ_q, integ_d;
  logic signed [IB:0]                integ_sum;
  logic signed [lfpd_pkg::DIFF_W-1:0] diff_d;
  lfpd_pkg::lfpd_decode_t            dec;

  always_comb begin
    dec       = lfpd_pkg::decode_pattern(s_axis_tdata[4:0]);
    cur_err_d = dec.hit ? $signed(dec.err) : cur_err_q;
    // The sum is one bit wider. If its top two bits differ, it saturates
    // toward its sign.
    integ_sum = {integ_q[IB-1], integ_q} + (IB + 1)'(cur_err_d);
    if (integ_sum[IB] != integ_sum[IB-1]) begin
      integ_d = {integ_sum[IB], {(IB - 1){~integ_sum[IB]}}};
    end else begin
      integ_d = integ_sum[IB-1:0];
    end
    diff_d = lfpd_pkg::DIFF_W'(cur_err_d) - lfpd_pkg::DIFF_W'(prev_err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_err_q  <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
    end else if (in_acc) begin
      cur_err_q  <= cur_err_d;
      prev_err_q <= cur_err_d;
      integ_q    <= integ_d;
    end
  end

  // Term stage. It holds the error, integral and change for one tick.
  logic signed [lfpd_pkg::ERR_W-1:0]  s1_err_q;
  logic signed [IB-1:0]               s1_integ_q;
  logic signed [lfpd_pkg::DIFF_W-1:0] s1_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_err_q   <= cur_err_d;
      s1_integ_q <= integ_d;
      s1_diff_q  <= diff_d;
    end
  end

  // Weighted sum and clamp to plus or minus base_speed.
  logic signed [lfpd_pkg::PID_W-1:0] prod_p, prod_i, prod_d, pid, lim;
  logic signed [lfpd_pkg::PID_W-1:0] corr;
  logic [lfpd_pkg::GAIN_W-1:0]       mag;
  logic [lfpd_pkg::GAIN_W-1:0]       left_d, right_d;

  always_comb begin
    prod_p = $signed({1'b0, gain_p_q}) * s1_err_q;
    prod_i = $signed({1'b0, gain_i_q}) * s1_integ_q;
    prod_d = $signed({1'b0, gain_d_q}) * s1_diff_q;
    pid    = prod_p + prod_i + prod_d;
    lim    = $signed({{(lfpd_pkg::PID_W - lfpd_pkg::GAIN_W){1'b0}}, base_speed_q});
    if (pid > lim) begin
      corr = lim;
    end else if (pid < -lim) begin
      corr = -lim;
    end else begin
      corr = pid;
    end
    // The clamp keeps the magnitude of the correction within base_speed,
    // so it fits in eight bits.
    if (corr < 0) begin
      mag     = lfpd_pkg::GAIN_W'(-corr);
      left_d  = base_speed_q - mag;
      right_d = base_speed_q;
    end else begin
      mag     = lfpd_pkg::GAIN_W'(corr);
      left_d  = base_speed_q;
      right_d = base_speed_q - mag;
    end
  end

  // Result register.
  logic [lfpd_pkg::GAIN_W-1:0] left_q, right_q;
  logic [lfpd_pkg::ERR_W-1:0]  line_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q     <= left_d;
      right_q    <= right_d;
      line_err_q <= s1_err_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, line_err_q, right_q, left_q};

endmodule
